>>> rtl/slfr_pkg.sv
// Shared constants and helper functions for the frame receiver queue.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package slfr_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;
    localparam int QUEUE_SLOTS_DEF = 4;
    localparam int MAX_RESULTS     = 32;
    localparam int DESC_DEPTH      = 2;
    localparam int OUT_DEPTH       = 2;
    localparam int OUT_DATA_W      = 56;

    localparam logic [7:0] SYNC_A = 8'hAA;
    localparam logic [7:0] SYNC_B = 8'h55;

    // The store holds the queued frames, one free slot for the frame being
    // received, and the slots still being read out by the back end.
    function automatic int slot_count(input int queue_slots);
        return queue_slots + DESC_DEPTH + 2;
    endfunction

    function automatic int idx_width(input int max_payload);
        return (max_payload > 1) ? $clog2(max_payload) : 1;
    endfunction

endpackage

>>> rtl/sync_length_frame_receiver_queue.sv
// Top level: length-prefixed frame receiver with checksum and a queue of frames.
// Depends on slfr_pkg, slfr_fifo, slfr_front and slfr_back.
// Line bytes are taken one per cycle while the descriptor queue has room, and
// produce no output. An idle back end loads a pop's request, reads the store and
// buffers each result, then presents one per cycle while the receiver is ready;
// the input stalls while two pop requests wait behind the readout. Reset is synchronous.
`timescale 1ns / 1ps

module sync_length_frame_receiver_queue
    import slfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [15:0]           i_s_tdata,  // rx_byte[7:0], max_len[15:8]
    input  logic                  i_s_tuser,  // cmd[0]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,  // data_byte[7:0], delivered_len[15:8],
                                              // frames_queued[23:16], valid_frames[55:24]
    output logic                  o_m_tuser,  // has_data[0]
    output logic                  o_m_tlast
);

    localparam int SLOT_W = $clog2(slot_count(QUEUE_SLOTS));
    localparam int IDX_W  = idx_width(MAX_PAYLOAD);
    localparam int DW     = 8 + SLOT_W + 8 + 32;

    logic              w_fe_ready;
    logic              w_push_valid;
    logic              w_push_ready;
    logic [7:0]        w_push_len;
    logic [SLOT_W-1:0] w_push_slot;
    logic [7:0]        w_push_queued;
    logic [31:0]       w_push_total;
    logic [DW-1:0]     w_push_data;

    logic              w_desc_valid;
    logic              w_desc_ready;
    logic [DW-1:0]     w_desc_data;

    logic              w_wr_en;
    logic [SLOT_W-1:0] w_wr_slot;
    logic [IDX_W-1:0]  w_wr_idx;
    logic [7:0]        w_wr_data;

    assign o_s_tready = w_fe_ready;

    slfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .o_ready       (w_fe_ready),
        .i_cmd         (i_s_tuser),
        .i_rx_byte     (i_s_tdata[7:0]),
        .i_max_len     (i_s_tdata[15:8]),
        .i_desc_ready  (w_push_ready),
        .o_desc_valid  (w_push_valid),
        .o_desc_len    (w_push_len),
        .o_desc_slot   (w_push_slot),
        .o_desc_queued (w_push_queued),
        .o_desc_total  (w_push_total),
        .o_wr_en       (w_wr_en),
        .o_wr_slot     (w_wr_slot),
        .o_wr_idx      (w_wr_idx),
        .o_wr_data     (w_wr_data)
    );

    assign w_push_data = {w_push_total, w_push_queued, w_push_slot, w_push_len};

    slfr_fifo #(
        .WIDTH (DW),
        .DEPTH (DESC_DEPTH)
    ) u_desc_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_push_valid),
        .o_ready (w_push_ready),
        .i_data  (w_push_data),
        .o_valid (w_desc_valid),
        .i_ready (w_desc_ready),
        .o_data  (w_desc_data),
        .o_count ()
    );

    slfr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (w_wr_en),
        .i_wr_slot     (w_wr_slot),
        .i_wr_idx      (w_wr_idx),
        .i_wr_data     (w_wr_data),
        .i_desc_valid  (w_desc_valid),
        .o_desc_ready  (w_desc_ready),
        .i_desc_len    (w_desc_data[7:0]),
        .i_desc_slot   (w_desc_data[8 +: SLOT_W]),
        .i_desc_queued (w_desc_data[8 + SLOT_W +: 8]),
        .i_desc_total  (w_desc_data[16 + SLOT_W +: 32]),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast)
    );

endmodule

>>> rtl/slfr_fifo.sv
// Small register FIFO with a valid/ready handshake on both sides.
// Depends on slfr_pkg for its default depth.
`timescale 1ns / 1ps

module slfr_fifo
    import slfr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = DESC_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_data[r_rp];
    assign o_count = r_cnt;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wp] <= i_data;
        end
    end

endmodule

>>> rtl/slfr_front.sv
// Front end: frame parser, checksum, slot bookkeeping and pop descriptors.
// Depends on slfr_pkg; writes payload bytes into the store in slfr_back.
`timescale 1ns / 1ps

module slfr_front
    import slfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic                                       i_cmd,
    input  logic [7:0]                                 i_rx_byte,
    input  logic [7:0]                                 i_max_len,
    input  logic                                       i_desc_ready,
    output logic                                       o_desc_valid,
    output logic [7:0]                                 o_desc_len,
    output logic [$clog2(slot_count(QUEUE_SLOTS))-1:0] o_desc_slot,
    output logic [7:0]                                 o_desc_queued,
    output logic [31:0]                                o_desc_total,
    output logic                                       o_wr_en,
    output logic [$clog2(slot_count(QUEUE_SLOTS))-1:0] o_wr_slot,
    output logic [idx_width(MAX_PAYLOAD)-1:0]          o_wr_idx,
    output logic [7:0]                                 o_wr_data
);

    localparam int SLOTS  = slot_count(QUEUE_SLOTS);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int IDX_W  = idx_width(MAX_PAYLOAD);

    typedef enum logic [4:0] {
        ST_HUNT    = 5'b00001,
        ST_SYNC2   = 5'b00010,
        ST_LEN     = 5'b00100,
        ST_PAYLOAD = 5'b01000,
        ST_SUM     = 5'b10000
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [7:0]        r_exp_len, n_exp_len;
    logic [7:0]        r_idx, n_idx;
    logic [7:0]        r_sum, n_sum;
    logic [SLOT_W-1:0] r_wr_slot, n_wr_slot;
    logic [SLOT_W-1:0] r_rd_slot, n_rd_slot;
    logic [7:0]        r_count, n_count;
    logic [31:0]       r_total, n_total;
    logic [7:0]        r_slot_len [SLOTS];

    logic       w_accept;
    logic       w_commit;
    logic [7:0] w_len;
    logic [7:0] w_take;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    assign o_ready  = i_desc_ready;
    assign w_accept = i_valid && i_desc_ready;
    assign w_len    = r_slot_len[r_rd_slot];

    always_comb begin
        w_take = (i_max_len < w_len) ? i_max_len : w_len;
        if (w_take > 8'(MAX_RESULTS)) begin
            w_take = 8'(MAX_RESULTS);
        end
    end

    assign o_desc_valid  = w_accept && i_cmd;
    assign o_desc_len    = (r_count == '0) ? '0 : w_take;
    assign o_desc_slot   = r_rd_slot;
    assign o_desc_queued = (r_count == '0) ? '0 : r_count - 8'd1;
    assign o_desc_total  = r_total;

    assign o_wr_en   = w_accept && !i_cmd && (r_phase == ST_PAYLOAD);
    assign o_wr_slot = r_wr_slot;
    assign o_wr_idx  = r_idx[IDX_W-1:0];
    assign o_wr_data = i_rx_byte;

    assign w_commit = w_accept && !i_cmd && (r_phase == ST_SUM)
                      && (i_rx_byte == r_sum) && (r_count < 8'(QUEUE_SLOTS));

    always_comb begin
        n_phase   = r_phase;
        n_exp_len = r_exp_len;
        n_idx     = r_idx;
        n_sum     = r_sum;
        n_wr_slot = r_wr_slot;
        n_rd_slot = r_rd_slot;
        n_count   = r_count;
        n_total   = r_total;
        if (w_accept && !i_cmd) begin
            unique case (r_phase)
                ST_HUNT: begin
                    if (i_rx_byte == SYNC_A) begin
                        n_phase = ST_SYNC2;
                    end
                end
                ST_SYNC2: begin
                    if (i_rx_byte == SYNC_B) begin
                        n_phase = ST_LEN;
                    end else if (i_rx_byte != SYNC_A) begin
                        n_phase = ST_HUNT;
                    end
                end
                ST_LEN: begin
                    if (i_rx_byte >= 8'd1 && i_rx_byte <= 8'(MAX_PAYLOAD)) begin
                        n_exp_len = i_rx_byte;
                        n_idx     = '0;
                        n_sum     = SYNC_A + SYNC_B + i_rx_byte;
                        n_phase   = ST_PAYLOAD;
                    end else begin
                        n_phase = ST_HUNT;
                    end
                end
                ST_PAYLOAD: begin
                    n_sum = r_sum + i_rx_byte;
                    n_idx = r_idx + 8'd1;
                    if (r_idx + 8'd1 >= r_exp_len) begin
                        n_phase = ST_SUM;
                    end
                end
                ST_SUM: begin
                    if (i_rx_byte == r_sum) begin
                        n_total = r_total + 32'd1;
                    end
                    if (w_commit) begin
                        n_wr_slot = next_slot(r_wr_slot);
                        n_count   = r_count + 8'd1;
                    end
                    n_phase = ST_HUNT;
                end
                default: begin
                    n_phase = ST_HUNT;
                end
            endcase
        end else if (w_accept && i_cmd && (r_count != '0)) begin
            n_count   = r_count - 8'd1;
            n_rd_slot = next_slot(r_rd_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ST_HUNT;
            r_exp_len <= '0;
            r_idx     <= '0;
            r_wr_slot <= '0;
            r_rd_slot <= '0;
            r_count   <= '0;
            r_total   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_exp_len <= n_exp_len;
            r_idx     <= n_idx;
            r_wr_slot <= n_wr_slot;
            r_rd_slot <= n_rd_slot;
            r_count   <= n_count;
            r_total   <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        if (w_commit) begin
            r_slot_len[r_wr_slot] <= r_exp_len;
        end
    end

endmodule

>>> rtl/slfr_back.sv
// Back end: frame store, readout sequencer and output buffer.
// Depends on slfr_pkg and slfr_fifo; takes pop requests from the descriptor queue.
`timescale 1ns / 1ps

module slfr_back
    import slfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_wr_en,
    input  logic [$clog2(slot_count(QUEUE_SLOTS))-1:0] i_wr_slot,
    input  logic [idx_width(MAX_PAYLOAD)-1:0]          i_wr_idx,
    input  logic [7:0]                                 i_wr_data,
    input  logic                                       i_desc_valid,
    output logic                                       o_desc_ready,
    input  logic [7:0]                                 i_desc_len,
    input  logic [$clog2(slot_count(QUEUE_SLOTS))-1:0] i_desc_slot,
    input  logic [7:0]                                 i_desc_queued,
    input  logic [31:0]                                i_desc_total,
    output logic                                       o_m_tvalid,
    input  logic                                       i_m_tready,
    output logic [OUT_DATA_W-1:0]                      o_m_tdata,
    output logic                                       o_m_tuser,
    output logic                                       o_m_tlast
);

    localparam int SLOTS  = slot_count(QUEUE_SLOTS);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int IDX_W  = idx_width(MAX_PAYLOAD);
    localparam int CW     = $clog2(OUT_DEPTH + 1);
    localparam int EW     = OUT_DATA_W + 2;

    logic [7:0]        r_mem [SLOTS][MAX_PAYLOAD];
    logic [7:0]        r_rd_data;

    logic              r_act;
    logic [7:0]        r_idx;
    logic [7:0]        r_n;
    logic [SLOT_W-1:0] r_slot;
    logic [7:0]        r_q;
    logic [31:0]       r_tot;

    logic              r_p_valid;
    logic              r_p_has;
    logic              r_p_last;
    logic [7:0]        r_p_n;
    logic [7:0]        r_p_q;
    logic [31:0]       r_p_tot;

    logic              w_load;
    logic              w_issue;
    logic              w_last;
    logic              w_pop;
    logic [CW-1:0]     w_cnt;
    logic [7:0]        w_byte;
    logic [EW-1:0]     w_entry;
    logic [EW-1:0]     w_head;

    assign o_desc_ready = !r_act;
    assign w_load       = !r_act && i_desc_valid;
    assign w_pop        = o_m_tvalid && i_m_tready;
    assign w_issue      = r_act && ((CW+1)'(w_cnt) + (CW+1)'(r_p_valid)
                                    < (CW+1)'(OUT_DEPTH) + (CW+1)'(w_pop));
    assign w_last       = (r_n == '0) || (r_idx + 8'd1 == r_n);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_slot][i_wr_idx] <= i_wr_data;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_slot][r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= 1'b0;
            r_idx     <= '0;
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= w_issue;
            if (w_load) begin
                r_act <= 1'b1;
                r_idx <= '0;
            end else if (w_issue) begin
                if (w_last) begin
                    r_act <= 1'b0;
                end else begin
                    r_idx <= r_idx + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_n    <= i_desc_len;
            r_slot <= i_desc_slot;
            r_q    <= i_desc_queued;
            r_tot  <= i_desc_total;
        end
        if (w_issue) begin
            r_p_has  <= (r_n != '0);
            r_p_last <= w_last;
            r_p_n    <= r_n;
            r_p_q    <= r_q;
            r_p_tot  <= r_tot;
        end
    end

    assign w_byte  = r_p_has ? r_rd_data : 8'd0;
    assign w_entry = {r_p_last, r_p_has, r_p_tot, r_p_q, r_p_n, w_byte};

    slfr_fifo #(
        .WIDTH (EW),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p_valid),
        .o_ready (),
        .i_data  (w_entry),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (w_head),
        .o_count (w_cnt)
    );

    assign o_m_tdata = w_head[OUT_DATA_W-1:0];
    assign o_m_tuser = w_head[OUT_DATA_W];
    assign o_m_tlast = w_head[OUT_DATA_W+1];

endmodule

>>> verif/tb.sv
// Self-checking testbench for sync_length_frame_receiver_queue.
// Uses slfr_pkg and the RTL; line bytes and pop requests are checked beat by beat
// against an in-bench model of the deframer and its frame queue.
`timescale 1ns / 1ps

module tb;
    import slfr_pkg::*;

    localparam int MAXP = MAX_PAYLOAD_DEF;
    localparam int QSLOTS = QUEUE_SLOTS_DEF;
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_POP = 1'b1;
    localparam int IDLE_PCT = 23;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int REQUEST_TOTAL = 350;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [4:0] {
        HUNT_A   = 5'b00001,
        WAIT_B   = 5'b00010,
        GET_LEN  = 5'b00100,
        GET_BODY = 5'b01000,
        GET_SUM  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        has;
        logic [7:0]  dlen;
        logic [7:0]  fq;
        logic [31:0] vf;
    } t_pop_beat;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx;
        logic [7:0] ml;
        logic       fixed;
        t_pop_beat  want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [15:0]           i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;

    sync_length_frame_receiver_queue #(
        .MAX_PAYLOAD(MAXP),
        .QUEUE_SLOTS(QSLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser),
        .o_m_tlast(o_m_tlast)
    );

    // Model state of the deframer and the frame queue.
    t_phase      phase = HUNT_A;
    logic [7:0]  exp_len = '0;
    int          body_idx = 0;
    logic [7:0]  asm_buf [MAXP];
    logic [7:0]  frame_mem [QSLOTS][MAXP];
    logic [7:0]  slot_len [QSLOTS];
    int          rd_slot = 0;
    int          wr_slot = 0;
    int          n_queued = 0;
    logic [31:0] good_total = '0;

    t_pop_beat expected_beats [$];
    t_row      directed_rows [$];

    int  error_count = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    int  requests_sent = 0;
    int  pops_sent = 0;
    int  beats_checked = 0;
    int  full_drops = 0;
    int  hold_left = 0;
    bit  hold_req = 0;
    bit  idle_on = 1;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic deframe_predict(input logic cmd, input logic [7:0] rx,
                                   input logic [7:0] ml, input bit keep);
        logic [7:0] sum;
        int         n;
        int         rs;
        t_pop_beat  b;
        if (cmd == CMD_BYTE) begin
            case (phase)
                HUNT_A: begin
                    if (rx == SYNC_A) phase = WAIT_B;
                end
                WAIT_B: begin
                    if (rx == SYNC_B) phase = GET_LEN;
                    else if (rx != SYNC_A) phase = HUNT_A;
                end
                GET_LEN: begin
                    if (rx >= 1 && rx <= MAXP) begin
                        exp_len = rx;
                        body_idx = 0;
                        phase = GET_BODY;
                    end else begin
                        phase = HUNT_A;
                    end
                end
                GET_BODY: begin
                    if (body_idx < MAXP) asm_buf[body_idx] = rx;
                    body_idx = body_idx + 1;
                    if (body_idx >= exp_len) phase = GET_SUM;
                end
                GET_SUM: begin
                    sum = SYNC_A + SYNC_B + exp_len;
                    for (int i = 0; i < exp_len; i++) sum = sum + asm_buf[i];
                    if (rx == sum) begin
                        if (n_queued < QSLOTS) begin
                            for (int i = 0; i < exp_len; i++) frame_mem[wr_slot][i] = asm_buf[i];
                            slot_len[wr_slot] = exp_len;
                            wr_slot = (wr_slot + 1) % QSLOTS;
                            n_queued = n_queued + 1;
                        end else begin
                            full_drops = full_drops + 1;
                        end
                        good_total = good_total + 1;
                    end
                    phase = HUNT_A;
                end
                default: begin
                    phase = HUNT_A;
                end
            endcase
            return;
        end
        b = '0;
        b.last = 1'b1;
        if (n_queued == 0) begin
            b.vf = good_total;
            if (keep) expected_beats.push_back(b);
            return;
        end
        rs = rd_slot;
        n = slot_len[rs];
        if (n > MAXP) n = MAXP;
        if (ml < n) n = ml;
        if (n > MAX_RESULTS) n = MAX_RESULTS;
        n_queued = n_queued - 1;
        rd_slot = (rs + 1) % QSLOTS;
        b.fq = 8'(n_queued);
        b.vf = good_total;
        if (n == 0) begin
            if (keep) expected_beats.push_back(b);
            return;
        end
        for (int i = 0; i < n; i++) begin
            b.data = frame_mem[rs][i];
            b.last = (i == n - 1);
            b.has = 1'b1;
            b.dlen = 8'(n);
            if (keep) expected_beats.push_back(b);
        end
    endtask

    task automatic push_request(input logic cmd, input logic [7:0] rx,
                                input logic [7:0] ml, input bit keep);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tuser = cmd;
        i_s_tdata = {ml, rx};
        do @(posedge i_clk); while (!o_s_tready);
        requests_sent = requests_sent + 1;
        if (cmd == CMD_POP) pops_sent = pops_sent + 1;
        deframe_predict(cmd, rx, ml, keep);
    endtask

    task automatic send_frame(input int len, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] pay;
        sum = SYNC_A + SYNC_B + 8'(len);
        push_request(CMD_BYTE, SYNC_A, 8'($urandom), 1'b1);
        push_request(CMD_BYTE, SYNC_B, 8'($urandom), 1'b1);
        push_request(CMD_BYTE, 8'(len), 8'($urandom), 1'b1);
        for (int i = 0; i < len; i++) begin
            pay = 8'($urandom);
            sum = sum + pay;
            push_request(CMD_BYTE, pay, 8'($urandom), 1'b1);
        end
        if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
        push_request(CMD_BYTE, sum, 8'($urandom), 1'b1);
    endtask

    task automatic add_row(input logic cmd, input logic [7:0] rx, input logic [7:0] ml,
                           input logic fixed, input t_pop_beat want);
        t_row r;
        r.cmd = cmd;
        r.rx = rx;
        r.ml = ml;
        r.fixed = fixed;
        r.want = want;
        directed_rows.push_back(r);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
    endtask

    // The receiver holds off for a counted stretch when the sender asks for it.
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_m_tready = 1'b0;
            end else begin
                i_m_tready = !idle_on || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        t_pop_beat got;
        t_pop_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.data = o_m_tdata[7:0];
            got.dlen = o_m_tdata[15:8];
            got.fq = o_m_tdata[23:16];
            got.vf = o_m_tdata[55:24];
            got.has = o_m_tuser;
            got.last = o_m_tlast;
            beats_checked = beats_checked + 1;
            if (expected_beats.size() == 0) begin
                error_count = error_count + 1;
                mismatches = mismatches + 1;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with nothing expected: data %h last %b has %b",
                             $time, got.data, got.last, got.has);
            end else begin
                want = expected_beats.pop_front();
                if (got !== want) begin
                    error_count = error_count + 1;
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: expected data %h last %b has %b len %0d queued %0d good %0d",
                                 $time, want.data, want.last, want.has, want.dlen, want.fq,
                                 want.vf);
                        $display("%0t:      got data %h last %b has %b len %0d queued %0d good %0d",
                                 $time, got.data, got.last, got.has, got.dlen, got.fq, got.vf);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int         pick;
        int         len;
        logic [7:0] ml;
        t_row       r;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = CMD_BYTE;

        // Pop on an empty queue, a one-byte frame popped with a zero limit, a repeated
        // first sync byte before a zero length, an all-ones frame, and a bad checksum.
        add_row(CMD_POP, 8'h00, 8'hFF, 1'b1, {8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 32'd0});
        add_row(CMD_BYTE, SYNC_A, 8'h00, 1'b0, '0);
        add_row(CMD_BYTE, SYNC_B, 8'hFF, 1'b0, '0);
        add_row(CMD_BYTE, 8'h01, 8'h00, 1'b0, '0);
        add_row(CMD_BYTE, 8'h00, 8'hFF, 1'b0, '0);
        add_row(CMD_BYTE, 8'h00, 8'h00, 1'b0, '0);
        add_row(CMD_POP, 8'hFF, 8'h00, 1'b1, {8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 32'd1});
        add_row(CMD_BYTE, SYNC_A, 8'h00, 1'b0, '0);
        add_row(CMD_BYTE, SYNC_A, 8'h00, 1'b0, '0);
        add_row(CMD_BYTE, SYNC_B, 8'h00, 1'b0, '0);
        add_row(CMD_BYTE, 8'h00, 8'h00, 1'b0, '0);
        add_row(CMD_BYTE, SYNC_A, 8'hFF, 1'b0, '0);
        add_row(CMD_BYTE, SYNC_B, 8'hFF, 1'b0, '0);
        add_row(CMD_BYTE, 8'h01, 8'hFF, 1'b0, '0);
        add_row(CMD_BYTE, 8'hFF, 8'hFF, 1'b0, '0);
        add_row(CMD_BYTE, 8'hFF, 8'hFF, 1'b0, '0);
        add_row(CMD_POP, 8'h00, 8'hFF, 1'b1, {8'hFF, 1'b1, 1'b1, 8'h01, 8'h00, 32'd2});
        add_row(CMD_BYTE, SYNC_A, 8'h00, 1'b0, '0);
        add_row(CMD_BYTE, SYNC_B, 8'h00, 1'b0, '0);
        add_row(CMD_BYTE, 8'h01, 8'h00, 1'b0, '0);
        add_row(CMD_BYTE, 8'h00, 8'h00, 1'b0, '0);
        add_row(CMD_BYTE, 8'h01, 8'h00, 1'b0, '0);
        add_row(CMD_POP, 8'hFF, 8'h01, 1'b1, {8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 32'd2});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[k]) begin
            r = directed_rows[k];
            push_request(r.cmd, r.rx, r.ml, !r.fixed);
            if (r.fixed) expected_beats.push_back(r.want);
        end

        // Fill the queue past full, then pop while the receiver is held off.
        send_frame(MAXP, 1'b0);
        send_frame(8, 1'b0);
        send_frame(8, 1'b0);
        send_frame(8, 1'b0);
        send_frame(4, 1'b0);
        hold_req = 1;
        repeat (6) push_request(CMD_POP, 8'($urandom), 8'hFF, 1'b1);
        wait_drained();

        while (requests_sent < REQUEST_TOTAL) begin
            idle_on = !(requests_sent >= 220 && requests_sent < 300);
            pick = $urandom_range(99);
            if (pick < 55) begin
                len = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, MAXP);
                send_frame(len, $urandom_range(99) < 10);
            end else if (pick < 62) begin
                push_request(CMD_BYTE, SYNC_A, 8'($urandom), 1'b1);
                if ($urandom_range(1)) push_request(CMD_BYTE, SYNC_A, 8'($urandom), 1'b1);
                push_request(CMD_BYTE, SYNC_B, 8'($urandom), 1'b1);
                push_request(CMD_BYTE,
                             $urandom_range(1) ? 8'h00 : 8'($urandom_range(MAXP + 1, 255)),
                             8'($urandom), 1'b1);
            end else if (pick < 88) begin
                pick = $urandom_range(99);
                if (pick < 50) ml = 8'hFF;
                else if (pick < 75) ml = 8'($urandom_range(0, 8));
                else ml = 8'($urandom);
                push_request(CMD_POP, 8'($urandom), ml, 1'b1);
            end else begin
                push_request(CMD_BYTE, 8'($urandom), 8'($urandom), 1'b1);
            end
        end
        idle_on = 1;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_beats.size() != 0) error_count = error_count + 1;

        $display("Covered %0d requests with %0d pops, checking %0d output beats.",
                 requests_sent, pops_sent, beats_checked);
        $display("Frames with a good checksum: %0d, of which %0d arrived with the queue full.",
                 good_total, full_drops);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
